// ===== rtl/core/bbps_pkg.sv =====
// Shared types and constants of the bicubic Bezier patch sampler.
// Used by the controller, the datapath and the top level; no dependencies.
package bbps_pkg;

  localparam int COORD_W      = 32;
  localparam int TWIST_W      = 34;
  localparam int WEIGHT_W     = 17;
  localparam int WEIGHT_FRAC  = 16;
  localparam int SLOTS        = 12;
  localparam int DIV_STEPS    = 17;
  localparam int OPA_W        = 38;
  localparam int OPB_W        = 18;
  localparam int PROD_W       = 56;
  localparam int ROW_W        = 54;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [2:0] ROW_DONE = 3'd4;
  localparam logic [2:0] LAST_W   = 3'd7;
  localparam logic [4:0] LAST_DIV = 5'(DIV_STEPS - 1);

  localparam logic [2:0] REG_U_INTERVALS = 3'd0;
  localparam logic [2:0] REG_V_INTERVALS = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WSET1,
    S_WSET2,
    S_WDIV,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       wset1;
    logic       wset2;
    logic       div_step;
    logic       w_store;
    logic       mul;
    logic       acc;
    logic       out_load;
    logic [2:0] widx;
    logic [2:0] bi;
    logic [1:0] bj;
  } cmd_t;

endpackage

// ===== rtl/core/bbps_ctrl.sv =====
// Controller of the patch sampler: state machine, weight, divider and term counters.
// Depends on bbps_pkg; drives bbps_datapath through a cmd_t bundle.
module bbps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  output logic          out_valid,
  input  logic          out_ready,
  output bbps_pkg::cmd_t cmd
);
  import bbps_pkg::*;

  state_t     state, state_next;
  logic [2:0] widx;
  logic [4:0] dcnt;
  logic [2:0] bi;
  logic [1:0] bj;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && kind == KIND_EVAL) state_next = S_WSET1;
      S_WSET1: state_next = S_WSET2;
      S_WSET2: state_next = S_WDIV;
      S_WDIV: begin
        if (dcnt == LAST_DIV) state_next = (widx == LAST_W) ? S_MUL : S_WSET1;
      end
      S_MUL:   state_next = S_ACC;
      S_ACC: begin
        state_next = (bi == ROW_DONE && bj == 2'd3) ? S_OUT : S_MUL;
      end
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == S_IDLE);
    cmd              = '0;
    cmd.widx         = widx;
    cmd.bi           = bi;
    cmd.bj           = bj;
    cmd.load         = accept && kind == KIND_LOAD;
    cmd.capture      = accept && kind == KIND_EVAL;
    cmd.wset1        = (state == S_WSET1);
    cmd.wset2        = (state == S_WSET2);
    cmd.div_step     = (state == S_WDIV);
    cmd.w_store      = (state == S_WDIV) && dcnt == LAST_DIV;
    cmd.mul          = (state == S_MUL);
    cmd.acc          = (state == S_ACC);
    cmd.out_load     = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      widx      <= '0;
      dcnt      <= '0;
      bi        <= '0;
      bj        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        widx <= '0;
        bi   <= '0;
        bj   <= '0;
      end
      if (cmd.wset2) dcnt <= '0;
      if (cmd.div_step) begin
        dcnt <= dcnt + 5'd1;
        if (cmd.w_store) widx <= widx + 3'd1;
      end
      if (cmd.acc) begin
        if (bi == ROW_DONE) begin
          bi <= '0;
          bj <= bj + 2'd1;
        end else begin
          bi <= bi + 3'd1;
        end
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_EVAL) |=> state == S_WSET1)
    else $error("evaluate transaction did not start weight setup");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_WDIV && dcnt == LAST_DIV) |=> (state == S_WSET1 || state == S_MUL))
    else $error("divider did not hand over after its last step");

  a_sum_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && bi == ROW_DONE && bj == 2'd3) |=> state == S_OUT)
    else $error("accumulation did not finish after the last row");

  a_out_set: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result register loaded without valid");

endmodule

// ===== rtl/core/bbps_datapath.sv =====
// Datapath of the patch sampler: point storage, twists, weight divider and the MAC.
// Depends on bbps_pkg; sequenced by bbps_ctrl through a cmd_t bundle.
module bbps_datapath (
  input  logic                clk,
  input  bbps_pkg::cmd_t      cmd,
  input  logic [3:0]          slot,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic [7:0]          sample_u,
  input  logic [7:0]          sample_v,
  input  logic [7:0]          u_int,
  input  logic [7:0]          v_int,
  output logic signed [31:0]  surface_x,
  output logic signed [31:0]  surface_y,
  output logic [7:0]          index_u,
  output logic [7:0]          index_v
);
  import bbps_pkg::*;

  logic signed [COORD_W-1:0]  bpt [2][SLOTS];
  logic signed [TWIST_W-1:0]  tw  [2][4];
  logic signed [TWIST_W-1:0]  kv  [2];
  logic [7:0]  n_u, n_v, i_u, i_v, nu_c, nv_c;
  logic [7:0]  n_s, i_s, m_s, b_s;
  logic [15:0] pa, nn;
  logic [23:0] num, dd, dd_c;
  logic [25:0] num3;
  logic [41:0] div_acc, div_next, div_sh;
  logic [24:0] div_up;
  logic [WEIGHT_W-1:0] w [8];
  logic [WEIGHT_W-1:0] wsel;
  logic signed [ROW_W-1:0]  row [2];
  logic signed [ROW_W-1:0]  row_r [2];
  logic signed [PROD_W-1:0] accum [2];
  logic signed [PROD_W-1:0] fin [2];
  logic signed [PROD_W-1:0] prod [2];
  logic signed [OPA_W-1:0]  opa [2];
  logic signed [OPB_W-1:0]  opb;
  logic signed [39:0]       fr [2];
  logic signed [31:0]       sat [2];

  function automatic logic signed [TWIST_W-1:0] ext(input logic signed [COORD_W-1:0] v);
    return TWIST_W'(v);
  endfunction

  // Point storage and the parallelogram twists for the inner points.
  always_ff @(posedge clk) begin
    if (cmd.load && slot < 4'(SLOTS)) begin
      bpt[0][slot] <= point_x;
      bpt[1][slot] <= point_y;
    end
    for (int a = 0; a < 2; a++) begin
      tw[a][0] <= ext(bpt[a][1]) + ext(bpt[a][8])  - ext(bpt[a][0]);
      tw[a][1] <= ext(bpt[a][2]) + ext(bpt[a][10]) - ext(bpt[a][3]);
      tw[a][2] <= ext(bpt[a][5]) + ext(bpt[a][9])  - ext(bpt[a][4]);
      tw[a][3] <= ext(bpt[a][11]) + ext(bpt[a][6]) - ext(bpt[a][7]);
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      case ({cmd.bj, cmd.bi[1:0]})
        4'd0:    kv[a] = ext(bpt[a][0]);
        4'd1:    kv[a] = ext(bpt[a][1]);
        4'd2:    kv[a] = ext(bpt[a][2]);
        4'd3:    kv[a] = ext(bpt[a][3]);
        4'd4:    kv[a] = ext(bpt[a][8]);
        4'd5:    kv[a] = tw[a][0];
        4'd6:    kv[a] = tw[a][1];
        4'd7:    kv[a] = ext(bpt[a][10]);
        4'd8:    kv[a] = ext(bpt[a][9]);
        4'd9:    kv[a] = tw[a][2];
        4'd10:   kv[a] = tw[a][3];
        4'd11:   kv[a] = ext(bpt[a][11]);
        4'd12:   kv[a] = ext(bpt[a][4]);
        4'd13:   kv[a] = ext(bpt[a][5]);
        4'd14:   kv[a] = ext(bpt[a][6]);
        default: kv[a] = ext(bpt[a][7]);
      endcase
    end
  end

  // Interval counts of zero act as one; indices clamp to the count.
  assign nu_c = (u_int == 8'd0) ? 8'd1 : u_int;
  assign nv_c = (v_int == 8'd0) ? 8'd1 : v_int;

  // Weight setup: numerator and n cubed, then a restoring divide.
  assign n_s  = cmd.widx[2] ? n_v : n_u;
  assign i_s  = cmd.widx[2] ? i_v : i_u;
  assign m_s  = n_s - i_s;
  assign b_s  = (cmd.widx[1:0] == 2'd0 || cmd.widx[1:0] == 2'd2) ? m_s : i_s;
  assign num  = pa * b_s;
  assign num3 = (cmd.widx[1:0] == 2'd1 || cmd.widx[1:0] == 2'd2) ?
                26'(num) * 26'd3 : 26'(num);
  assign dd_c = nn * n_s;

  assign div_sh = {div_acc[40:0], 1'b0};
  assign div_up = div_sh[41:17];
  always_comb begin
    if (div_up >= {1'b0, dd}) div_next = {div_up - {1'b0, dd}, div_sh[16:1], 1'b1};
    else div_next = div_sh;
  end

  // Multiplier operands: a control point term, or a rounded row at the row end.
  assign wsel = (cmd.bi == ROW_DONE) ? w[{1'b1, cmd.bj}] : w[{1'b0, cmd.bi[1:0]}];
  assign opb  = {1'b0, wsel};
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      row_r[a] = row[a] + ROW_W'(32768);
      opa[a]   = (cmd.bi == ROW_DONE) ? row_r[a][ROW_W-1:WEIGHT_FRAC] : OPA_W'(kv[a]);
      fin[a]   = accum[a] + PROD_W'(32768);
      fr[a]    = fin[a][PROD_W-1:WEIGHT_FRAC];
      if (fr[a] > 40'sd2147483647) sat[a] = 32'sh7FFFFFFF;
      else if (fr[a] < -40'sd2147483648) sat[a] = 32'sh80000000;
      else sat[a] = fr[a][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_u <= nu_c;
      n_v <= nv_c;
      i_u <= (sample_u > nu_c) ? nu_c : sample_u;
      i_v <= (sample_v > nv_c) ? nv_c : sample_v;
      for (int a = 0; a < 2; a++) begin
        row[a]   <= '0;
        accum[a] <= '0;
      end
    end
    if (cmd.wset1) begin
      pa <= (cmd.widx[1:0] < 2'd2) ? m_s * m_s : i_s * i_s;
      nn <= n_s * n_s;
    end
    if (cmd.wset2) begin
      dd      <= dd_c;
      div_acc <= {num3, 16'd0} + 42'(dd_c[23:1]);
    end
    if (cmd.div_step) div_acc <= div_next;
    if (cmd.w_store) w[cmd.widx] <= div_next[WEIGHT_W-1:0];
    for (int a = 0; a < 2; a++) begin
      if (cmd.mul) prod[a] <= opa[a] * opb;
      if (cmd.acc) begin
        if (cmd.bi == ROW_DONE) begin
          accum[a] <= accum[a] + prod[a];
          row[a]   <= '0;
        end else begin
          row[a] <= row[a] + prod[a][ROW_W-1:0];
        end
      end
    end
    if (cmd.out_load) begin
      surface_x <= sat[0];
      surface_y <= sat[1];
      index_u   <= i_u;
      index_v   <= i_v;
    end
  end

endmodule

// ===== rtl/core/bicubic_bezier_patch_sampler_unit.sv =====
// Top level of the bicubic Bezier patch sampler: APB registers, controller, datapath.
// Depends on bbps_pkg, bbps_ctrl and bbps_datapath.
//
// The block holds the twelve boundary control points of a bicubic Bezier patch
// and returns points sampled on a regular grid. A load transaction (kind 0)
// writes one boundary point into a slot in the cycle it is accepted and gives
// no result; slots above eleven are ignored. The four inner points are kept as
// parallelogram twists of the boundary and follow each load in the next cycle.
// An evaluate transaction (kind 1) clamps its sample indices to the interval
// counts, forms the eight Bernstein weights one at a time with a shared
// bit-serial divider (states S_WSET1 and S_WSET2 to set up, then seventeen divide
// steps each), then runs the sixteen control point terms and four row terms
// through one multiply-accumulate pair, each term in states S_MUL and S_ACC.
// Transactions are accepted only in idle, so none is taken while an evaluate runs;
// the divider dominates. S_OUT waits while an earlier result is still held. The
// result waits in an output register, so the next transaction is accepted as
// soon as the sampler is back in idle, whether or not the result was taken.
// Results are signed Q15.16, rounded half up and saturated to 32 bits. The
// interval registers sit at byte addresses 0 and 4 and are to be written only
// while no evaluate is in flight.
module bicubic_bezier_patch_sampler_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [3:0]         slot,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [7:0]         sample_u,
  input  logic [7:0]         sample_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] surface_x,
  output logic signed [31:0] surface_y,
  output logic [7:0]         index_u,
  output logic [7:0]         index_v
);
  import bbps_pkg::*;

  logic [7:0] u_intervals;
  logic [7:0] v_intervals;
  logic       wr_en;
  cmd_t       cmd;

  // Registers decode on address bit two; each write takes the low byte of pwdata.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_V_INTERVALS[2]) ? {24'd0, v_intervals}
                                                   : {24'd0, u_intervals};

  always_ff @(posedge clk) begin
    if (rst) begin
      u_intervals <= 8'd60;
      v_intervals <= 8'd60;
    end else if (wr_en) begin
      if (paddr[2] == REG_U_INTERVALS[2]) u_intervals <= pwdata[7:0];
      else v_intervals <= pwdata[7:0];
    end
  end

  bbps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bbps_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .slot      (slot),
    .point_x   (point_x),
    .point_y   (point_y),
    .sample_u  (sample_u),
    .sample_v  (sample_v),
    .u_int     (u_intervals),
    .v_int     (v_intervals),
    .surface_x (surface_x),
    .surface_y (surface_y),
    .index_u   (index_u),
    .index_v   (index_v)
  );

endmodule

// ===== dv/bbps_scoreboard.sv =====
// Scoreboard for the bicubic Bezier patch sampler: predicts surface samples
// from loaded boundary points and the interval counts. Depends on bbps_pkg.
`timescale 1ns / 100ps

class bbps_scoreboard;
  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [7:0]         iu;
    logic [7:0]         iv;
  } sample_t;

  logic signed [31:0] pt_x[12];
  logic signed [31:0] pt_y[12];
  logic [7:0]         n_u;
  logic [7:0]         n_v;
  sample_t            pending[$];
  int                 mismatches;

  function void reset_state();
    n_u = 8'd60;
    n_v = 8'd60;
    pending.delete();
    for (int i = 0; i < 12; i++) begin
      pt_x[i] = '0;
      pt_y[i] = '0;
    end
  endfunction

  function void set_intervals(bit is_v, logic [7:0] val);
    if (is_v) n_v = val;
    else n_u = val;
  endfunction

  // Round half up: add half, then floor-shift (arithmetic shift floors).
  function longint rnd16(longint x);
    longint y;
    y = x + 64'sd32768;
    return y >>> 16;
  endfunction

  function void bern(longint n, longint i, output longint w[4]);
    longint m, d;
    longint num[4];
    m = n - i;
    d = n * n * n;
    num[0] = m * m * m;
    num[1] = 3 * i * m * m;
    num[2] = 3 * i * i * m;
    num[3] = i * i * i;
    for (int k = 0; k < 4; k++) w[k] = ((num[k] << 16) + d / 2) / d;
  endfunction

  function logic signed [31:0] surface_axis(bit is_y, longint wu[4], longint wv[4]);
    longint kp[16];
    longint acc, row, sum;
    int     slot_k[12] = '{0, 1, 2, 3, 12, 13, 14, 15, 4, 8, 7, 11};
    for (int s = 0; s < 12; s++) kp[slot_k[s]] = is_y ? longint'(pt_y[s]) : longint'(pt_x[s]);
    kp[5]  = kp[1] + kp[4] - kp[0];
    kp[6]  = kp[2] + kp[7] - kp[3];
    kp[9]  = kp[13] + kp[8] - kp[12];
    kp[10] = kp[11] + kp[14] - kp[15];
    acc = 0;
    for (int bj = 0; bj < 4; bj++) begin
      row = 0;
      for (int bi = 0; bi < 4; bi++) row += wu[bi] * kp[bi + 4 * bj];
      acc += wv[bj] * rnd16(row);
    end
    sum = rnd16(acc);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // Notes an accepted input transaction; evaluates queue an expected sample.
  function void note_input(logic knd, logic [3:0] sl, logic signed [31:0] px,
                           logic signed [31:0] py, logic [7:0] su, logic [7:0] sv);
    longint  nu, nv, iu, iv;
    longint  wu[4], wv[4];
    sample_t e;
    if (knd == bbps_pkg::KIND_LOAD) begin
      if (sl < 12) begin
        pt_x[sl] = px;
        pt_y[sl] = py;
      end
      return;
    end
    nu = (n_u == 0) ? 1 : n_u;
    nv = (n_v == 0) ? 1 : n_v;
    iu = (su > nu) ? nu : su;
    iv = (sv > nv) ? nv : sv;
    bern(nu, iu, wu);
    bern(nv, iv, wv);
    e.sx = surface_axis(0, wu, wv);
    e.sy = surface_axis(1, wu, wv);
    e.iu = iu[7:0];
    e.iv = iv[7:0];
    pending.push_back(e);
  endfunction

  function void check_sample(logic signed [31:0] sx, logic signed [31:0] sy,
                             logic [7:0] iu, logic [7:0] iv);
    sample_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected sample x=%0d y=%0d", sx, sy);
      return;
    end
    e = pending.pop_front();
    if (sx !== e.sx || sy !== e.sy || iu !== e.iu || iv !== e.iv) begin
      mismatches++;
      if (mismatches <= 10)
        $display("sample mismatch exp x=%0d y=%0d u=%0d v=%0d got x=%0d y=%0d u=%0d v=%0d",
                 e.sx, e.sy, e.iu, e.iv, sx, sy, iu, iv);
    end
  endfunction
endclass

// ===== dv/tb.sv =====
// Testbench top for bicubic_bezier_patch_sampler_unit: drives loads and
// evaluates with random gaps and checks samples. Depends on bbps_pkg, bbps_scoreboard.
`timescale 1ns / 100ps

module tb;
  import bbps_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 0;
  logic               in_ready;
  logic               kind = 0;
  logic [3:0]         slot = '0;
  logic signed [31:0] point_x = '0, point_y = '0;
  logic [7:0]         sample_u = '0, sample_v = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] surface_x, surface_y;
  logic [7:0]         index_u, index_v;

  bbps_scoreboard patch_model = new();
  longint         cycle_count = 0;
  int             out_hold = 0;
  // Loads give no result; this is the settling wait used before a register
  // write and at the end.
  localparam int SETTLE = 400;
  localparam longint CYCLE_LIMIT = 5_000_000;

  bicubic_bezier_patch_sampler_unit u_top (.*);

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bicubic_bezier_patch_sampler_unit");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Result side: out_ready toggles at random with an occasional long stall;
  // each transaction is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        patch_model.check_sample(surface_x, surface_y, index_u, index_v);
      if (out_hold > 0) begin
        out_hold  <= out_hold - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        out_hold  <= $urandom_range(20, 300);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    patch_model.set_intervals(addr == REG_V_INTERVALS, data[7:0]);
  endtask

  // Waits until every expected sample has come, then lets the block settle.
  task automatic drain();
    while (patch_model.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(logic knd, logic [3:0] sl, logic signed [31:0] px,
                      logic signed [31:0] py, logic [7:0] su, logic [7:0] sv);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; kind <= knd; slot <= sl;
    point_x <= px; point_y <= py; sample_u <= su; sample_v <= sv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    patch_model.note_input(knd, sl, px, py, su, sv);
  endtask

  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic load_patch();
    for (int s = 0; s < 12; s++)
      send(KIND_LOAD, s[3:0], rand_coord(), rand_coord(), 8'd0, 8'd0);
  endtask

  task automatic random_phase(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25)
        send(KIND_LOAD, 4'($urandom_range(0, 11)), rand_coord(), rand_coord(),
             8'($urandom), 8'($urandom));
      else if (r < 28)
        // Slots above eleven are ignored by the block.
        send(KIND_LOAD, 4'($urandom_range(12, 15)), rand_coord(), rand_coord(),
             8'($urandom), 8'($urandom));
      else if (r < 88)
        send(KIND_EVAL, 4'($urandom), $urandom, $urandom, 8'($urandom_range(0, 64)),
             8'($urandom_range(0, 64)));
      else
        send(KIND_EVAL, 4'($urandom), $urandom, $urandom, 8'($urandom), 8'($urandom));
    end
    idle_input();
  endtask

  initial begin
    patch_model.reset_state();
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: full patch, corners and edges of the grid, clamping, extremes.
    load_patch();
    send(KIND_LOAD, 4'd0, 32'sh7fffffff, 32'sh80000000, 8'hff, 8'hff);
    send(KIND_LOAD, 4'd15, 32'sh12345678, 32'sh0, 8'd0, 8'd0);
    send(KIND_EVAL, 4'd0, 0, 0, 8'd0, 8'd0);
    send(KIND_EVAL, 4'd0, 0, 0, 8'd60, 8'd60);
    send(KIND_EVAL, 4'd0, 0, 0, 8'd30, 8'd15);
    send(KIND_EVAL, 4'd15, -1, -1, 8'd255, 8'd0);
    send(KIND_EVAL, 4'd0, 0, 0, 8'd0, 8'd255);
    for (int s = 0; s < 12; s++)
      send(KIND_LOAD, s[3:0], (s % 2) ? 32'sh7fffffff : 32'sh80000000,
           (s % 2) ? 32'sh80000000 : 32'sh7fffffff, 8'd0, 8'd0);
    send(KIND_EVAL, 4'd0, 0, 0, 8'd20, 8'd40);
    send(KIND_EVAL, 4'd0, 0, 0, 8'd37, 8'd1);
    idle_input();

    // The interval settings cycle through extremes, zero and random values.
    drain();
    reg_write(REG_U_INTERVALS, 32'd0);
    reg_write(REG_V_INTERVALS, 32'd255);
    load_patch();
    random_phase(150);
    drain();
    reg_write(REG_U_INTERVALS, 32'd255);
    reg_write(REG_V_INTERVALS, 32'd1);
    random_phase(150);
    drain();
    reg_write(REG_U_INTERVALS, 32'd1);
    reg_write(REG_V_INTERVALS, 32'd0);
    random_phase(150);
    drain();
    reg_write(REG_U_INTERVALS, 32'hffffff03);
    reg_write(REG_V_INTERVALS, 32'd7);
    random_phase(150);
    drain();
    reg_write(REG_U_INTERVALS, $urandom_range(1, 255));
    reg_write(REG_V_INTERVALS, $urandom_range(1, 255));
    random_phase(150);
    drain();
    reg_write(REG_U_INTERVALS, 32'd60);
    reg_write(REG_V_INTERVALS, 32'd60);
    random_phase(130);

    drain();
    if (patch_model.mismatches == 0 && patch_model.pending.size() == 0)
      $display("PASS bicubic_bezier_patch_sampler_unit");
    else
      $display("FAIL bicubic_bezier_patch_sampler_unit");
    $finish;
  end
endmodule
